// ----- rtl/swva_pkg.sv -----
// shared types and constants for the sample window validate and average block
`default_nettype none
package swva_pkg;

	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 15;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FEW    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RISE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SPREAD = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MANY   = 3'd4;

	localparam logic [THR_W-1:0] THR_RESET = 15'd160;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic signed [SAMPLE_W-1:0] mean_temp;
	} out_item_t;

endpackage
`default_nettype wire

// ----- rtl/swva_queue.sv -----
// small register queue between the window front end and the divider back end
`default_nettype none
module swva_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1))
			return '0;
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_rd)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/swva_front.sv -----
// window tracker: running min, max, sum, count and rise flag, status at end of window
`default_nettype none
module swva_front #(
	parameter int MAX_SAMPLES = 256,
	parameter int SUM_W       = 24,
	parameter int CNT_W       = 9
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire swva_pkg::in_item_t       in_item,
	input  wire logic [swva_pkg::THR_W-1:0] threshold,
	output logic                          job_push,
	output logic [swva_pkg::STATUS_W-1:0] job_status,
	output logic signed [SUM_W-1:0]       job_sum,
	output logic [CNT_W-1:0]              job_cnt
);
	import swva_pkg::*;

	logic signed [SAMPLE_W-1:0] prev_q, min_q, max_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       rise_q;

	logic signed [SAMPLE_W-1:0] s, min_n, max_n;
	logic signed [SAMPLE_W:0]   diff, spread, thr_s;
	logic signed [SUM_W-1:0]    sum_n;
	logic [CNT_W-1:0]           cnt_n;
	logic                       rise_n;

	always_comb begin
		s      = in_item.sample;
		thr_s  = $signed({2'b00, threshold});
		diff   = $signed({s[SAMPLE_W-1], s}) - $signed({prev_q[SAMPLE_W-1], prev_q});
		rise_n = rise_q || ((cnt_q != '0) && (diff > thr_s));
		min_n  = (s < min_q) ? s : min_q;
		max_n  = (s > max_q) ? s : max_q;
		sum_n  = (cnt_q < CNT_W'(MAX_SAMPLES))
			? sum_q + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s} : sum_q;
		cnt_n  = (cnt_q <= CNT_W'(MAX_SAMPLES)) ? cnt_q + CNT_W'(1) : cnt_q;
		spread = $signed({max_n[SAMPLE_W-1], max_n}) - $signed({min_n[SAMPLE_W-1], min_n});

		priority if (cnt_n < CNT_W'(2))
			job_status = ST_FEW;
		else if (rise_n)
			job_status = ST_RISE;
		else if (spread > thr_s)
			job_status = ST_SPREAD;
		else if (cnt_n > CNT_W'(MAX_SAMPLES))
			job_status = ST_MANY;
		else
			job_status = ST_OK;
	end

	assign job_push = accept && in_item.last;
	assign job_sum  = sum_n;
	assign job_cnt  = cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			min_q  <= 16'sh7fff;
			max_q  <= 16'sh8000;
			sum_q  <= '0;
			cnt_q  <= '0;
			rise_q <= 1'b0;
		end else if (accept) begin
			if (in_item.last) begin
				prev_q <= '0;
				min_q  <= 16'sh7fff;
				max_q  <= 16'sh8000;
				sum_q  <= '0;
				cnt_q  <= '0;
				rise_q <= 1'b0;
			end else begin
				prev_q <= s;
				min_q  <= min_n;
				max_q  <= max_n;
				sum_q  <= sum_n;
				cnt_q  <= cnt_n;
				rise_q <= rise_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/swva_back.sv -----
// result stage: bit-serial mean division and output register
`default_nettype none
module swva_back #(
	parameter int SUM_W = 24,
	parameter int CNT_W = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      job_valid,
	input  wire logic [swva_pkg::STATUS_W-1:0] job_status,
	input  wire logic signed [SUM_W-1:0]   job_sum,
	input  wire logic [CNT_W-1:0]          job_cnt,
	output logic                           job_pop,
	output swva_pkg::out_item_t            out_item,
	output logic                           empty,
	input  wire logic                      pop
);
	import swva_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_DIV  = 2'b10
	} back_state_t;

	back_state_t         state_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [CNT_W-1:0]    rem_q, div_q;
	logic [SUM_W-1:0]    quo_q;
	logic                neg_q;
	logic [STEP_W-1:0]   step_q;

	logic                start, out_free, out_set;
	logic [CNT_W:0]      trial, rem_n;
	logic                ge;
	logic [SUM_W-1:0]    quo_n, mag;
	logic [SAMPLE_W-1:0] q16;

	assign out_free = !out_valid_q || pop;
	assign start    = (state_q == B_IDLE) && job_valid && out_free;
	assign out_set  = (start && (job_status != ST_OK)) || ((state_q == B_DIV) && (step_q == '0));
	assign job_pop  = start;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		ge    = trial >= {1'b0, div_q};
		rem_n = ge ? trial - {1'b0, div_q} : trial;
		quo_n = {quo_q[SUM_W-2:0], ge};
		q16   = neg_q ? SAMPLE_W'(-quo_n[SAMPLE_W-1:0]) : quo_n[SAMPLE_W-1:0];
		mag   = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : job_sum;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= job_cnt;
			quo_q <= mag;
			neg_q <= job_sum[SUM_W-1];
		end else if (state_q == B_DIV) begin
			rem_q <= rem_n[CNT_W-1:0];
			quo_q <= quo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			step_q      <= '0;
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						if (job_status == ST_OK) begin
							state_q <= B_DIV;
							step_q  <= STEP_W'(SUM_W - 1);
						end else begin
							out_q.status    <= job_status;
							out_q.mean_temp <= '0;
						end
					end
				end
				B_DIV: begin
					if (step_q == '0) begin
						state_q         <= B_IDLE;
						out_q.status    <= ST_OK;
						out_q.mean_temp <= $signed(q16);
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sample_window_validate_average_core.sv -----
// top level of the sample window validate and average block
// Takes one sample per cycle whenever the front end is not stalled; each accepted
// sample updates the running minimum, maximum, sum, count and rise flag. The last
// sample of a window hands status, sum and count to a two-entry queue. The back
// end divides sum by count one quotient bit per cycle for a window with ok status;
// other statuses go to the output register without a division. push is refused
// only while the queue holds two windows waiting for the divider.
`default_nettype none
module sample_window_validate_average_core #(
	parameter int MAX_SAMPLES = 256
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire swva_pkg::in_item_t         in_item,
	output logic                            empty,
	input  wire logic                       pop,
	output swva_pkg::out_item_t             out_item,
	input  wire logic                       cfg_we,
	input  wire logic [swva_pkg::THR_W-1:0] cfg_wdata
);
	import swva_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 2);
	localparam int JOB_W = STATUS_W + SUM_W + CNT_W;

	logic [THR_W-1:0]        thr_q;
	logic                    accept;
	logic                    job_push, q_empty, q_pop;
	logic [STATUS_W-1:0]     f_status, b_status;
	logic signed [SUM_W-1:0] f_sum, b_sum;
	logic [CNT_W-1:0]        f_cnt, b_cnt;
	logic [JOB_W-1:0]        q_wdata, q_rdata;

	assign accept  = push && !full;
	assign q_wdata = {f_status, f_sum, f_cnt};
	assign {b_status, b_sum, b_cnt} = q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (cfg_we)
			thr_q <= cfg_wdata;
	end

	swva_front #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_item(in_item),
		.threshold(thr_q),
		.job_push(job_push),
		.job_status(f_status),
		.job_sum(f_sum),
		.job_cnt(f_cnt)
	);

	swva_queue #(
		.WIDTH(JOB_W),
		.DEPTH(2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_data(q_wdata),
		.full(full),
		.rd_en(q_pop),
		.rd_data(q_rdata),
		.empty(q_empty)
	);

	swva_back #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(!q_empty),
		.job_status(b_status),
		.job_sum(b_sum),
		.job_cnt(b_cnt),
		.job_pop(q_pop),
		.out_item(out_item),
		.empty(empty),
		.pop(pop)
	);

endmodule
`default_nettype wire

// ----- test/sample_window_validate_average_core_test.sv -----
// testbench for the sample window validate and average core: table-driven and random windows
module sample_window_validate_average_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import swva_pkg::*;

	localparam int MAX_SAMPLES   = 256;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int PLAN_ROWS     = 31;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic [9:0]                 reps;
		logic                       pinned;
		logic [STATUS_W-1:0]        status;
		logic signed [SAMPLE_W-1:0] mean;
	} plan_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             push      = 1'b0;
	logic             full;
	in_item_t         in_item   = '0;
	logic             empty;
	logic             pop       = 1'b0;
	out_item_t        out_item;
	logic             cfg_we    = 1'b0;
	logic [THR_W-1:0] cfg_wdata = THR_RESET;

	logic [THR_W-1:0]           thr;
	logic signed [SAMPLE_W-1:0] win_prev, win_min, win_max;
	logic signed [24:0]         win_sum;
	logic [8:0]                 win_count;
	logic                       win_rise;

	out_item_t expected_q[$];
	out_item_t oldest;
	int        n_fail       = 0;
	int        n_items      = 0;
	int        burst_left   = 0;
	bit        rx_long_hold = 1'b0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{16'sd30000,   1'b1, 10'd1,   1'b1, ST_FEW,    16'sd0},
		'{-16'sd32768,  1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{-16'sd32768,  1'b1, 10'd1,   1'b1, ST_OK,     -16'sd32768},
		'{16'sd32767,   1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd32767,   1'b1, 10'd1,   1'b1, ST_OK,     16'sd32767},
		'{-16'sd32768,  1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd32767,   1'b1, 10'd1,   1'b1, ST_RISE,   16'sd0},
		'{16'sd0,       1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd161,     1'b1, 10'd1,   1'b1, ST_RISE,   16'sd0},
		'{16'sd0,       1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd160,     1'b1, 10'd1,   1'b1, ST_OK,     16'sd80},
		'{16'sd0,       1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{-16'sd161,    1'b1, 10'd1,   1'b1, ST_SPREAD, 16'sd0},
		'{16'sd0,       1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd100,     1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd200,     1'b1, 10'd1,   1'b1, ST_SPREAD, 16'sd0},
		'{-16'sd1,      1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{-16'sd2,      1'b1, 10'd1,   1'b1, ST_OK,     -16'sd1},
		'{-16'sd1000,   1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{-16'sd1000,   1'b1, 10'd1,   1'b1, ST_OK,     -16'sd1000},
		'{16'sd1000,    1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd1000,    1'b1, 10'd1,   1'b1, ST_OK,     16'sd1000},
		'{16'sd5,       1'b0, 10'd255, 1'b0, ST_OK,     16'sd0},
		'{16'sd5,       1'b1, 10'd1,   1'b1, ST_OK,     16'sd5},
		'{16'sd5,       1'b0, 10'd256, 1'b0, ST_OK,     16'sd0},
		'{16'sd5,       1'b1, 10'd1,   1'b1, ST_MANY,   16'sd0},
		'{16'sd0,       1'b0, 10'd300, 1'b0, ST_OK,     16'sd0},
		'{16'sd500,     1'b1, 10'd1,   1'b1, ST_RISE,   16'sd0},
		'{16'sd7,       1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{-16'sd3,      1'b0, 10'd1,   1'b0, ST_OK,     16'sd0},
		'{16'sd12,      1'b1, 10'd1,   1'b0, ST_OK,     16'sd0}
	};

	sample_window_validate_average_core #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void window_clear();
		win_prev  = '0;
		win_min   = 16'sh7fff;
		win_max   = -16'sh8000;
		win_sum   = '0;
		win_count = '0;
		win_rise  = 1'b0;
	endfunction

	function automatic bit window_step(input in_item_t it, output out_item_t res);
		int s;
		s = it.sample;
		res = '0;
		if (win_count != 0 && s - int'(win_prev) > int'(thr))
			win_rise = 1'b1;
		if (s < int'(win_min))
			win_min = it.sample;
		if (s > int'(win_max))
			win_max = it.sample;
		if (win_count < MAX_SAMPLES)
			win_sum = win_sum + it.sample;
		if (win_count <= MAX_SAMPLES)
			win_count = win_count + 1'b1;
		win_prev = it.sample;
		if (!it.last)
			return 1'b0;
		if (win_count < 2)
			res.status = ST_FEW;
		else if (win_rise)
			res.status = ST_RISE;
		else if (int'(win_max) - int'(win_min) > int'(thr))
			res.status = ST_SPREAD;
		else if (win_count > MAX_SAMPLES)
			res.status = ST_MANY;
		else begin
			res.status    = ST_OK;
			res.mean_temp = 16'(int'(win_sum) / int'(win_count));
		end
		window_clear();
		return 1'b1;
	endfunction

	task automatic note_fail(input string what, input out_item_t want, input out_item_t got);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t: %s: expected status %0d mean %0d, got status %0d mean %0d",
				$time, what, want.status, want.mean_temp, got.status, got.mean_temp);
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0)
				note_fail("unexpected result", '0, out_item);
			else begin
				oldest = expected_q.pop_front();
				if (out_item.status !== oldest.status || out_item.mean_temp !== oldest.mean_temp)
					note_fail("result mismatch", oldest, out_item);
			end
		end
	end

	task automatic offer(input in_item_t it, input bit pinned, input out_item_t pin_res);
		out_item_t res;
		int gap;
		push <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (window_step(it, res))
			expected_q.push_back(pinned ? pin_res : res);
		n_items++;
		if (burst_left > 0)
			burst_left--;
		else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr = v;
		@(posedge clk);
	endtask

	// windows of random length and shape; always ends on a complete window
	task automatic run_windows(input int count);
		in_item_t it;
		int stop, len, mode, s, step, r, i;
		stop = n_items + count;
		while (n_items < stop) begin
			mode = $urandom_range(0, 3);
			r = $urandom_range(0, 39);
			if (r == 0) begin
				case ($urandom_range(0, 4))
					0: len = 255;
					1: len = 256;
					2: len = 257;
					3: len = 258;
					default: len = 300;
				endcase
				mode = ($urandom_range(0, 1) == 0) ? 0 : 3;
			end else if (r < 5)
				len = 1;
			else
				len = $urandom_range(2, 24);
			case ($urandom_range(0, 7))
				0: s = -32768;
				1: s = 32767;
				default: s = int'($urandom_range(0, 65535)) - 32768;
			endcase
			for (i = 0; i < len; i++) begin
				case (mode)
					0: step = int'($urandom_range(0, 6)) - 3;
					1: step = int'($urandom_range(0, 400)) - 200;
					default: step = 0;
				endcase
				if (mode == 2)
					s = int'($urandom_range(0, 65535)) - 32768;
				else if (i > 0)
					s = s + step;
				if (s > 32767)
					s = 32767;
				if (s < -32768)
					s = -32768;
				it.sample = 16'(s);
				it.last = (i == len - 1);
				offer(it, 1'b0, '0);
			end
		end
	endtask

	initial begin : pop_pacing
		int mode, seg, tick;
		tick = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(16, 160);
			repeat (seg) begin
				if (rx_long_hold) begin
					pop <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					rx_long_hold = 1'b0;
				end
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ($urandom_range(0, 5) == 0);
					default: pop <= (tick % 4 == 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		in_item_t  it;
		out_item_t pin;
		thr = THR_RESET;
		window_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			it.sample = plan[r].sample;
			it.last = plan[r].last;
			pin.status = plan[r].status;
			pin.mean_temp = plan[r].mean;
			repeat (plan[r].reps) offer(it, plan[r].pinned, pin);
		end

		set_threshold(15'd0);
		run_windows(100);
		// receiver holds off while windows keep coming in
		set_threshold(15'h7fff);
		rx_long_hold = 1'b1;
		run_windows(220);
		set_threshold(15'd1);
		run_windows(100);
		set_threshold(15'($urandom_range(0, 32767)));
		run_windows(100);
		set_threshold(THR_RESET);
		run_windows(120);
		set_threshold(15'($urandom_range(2, 600)));
		run_windows(100);
		drain();

		if (n_fail == 0 && expected_q.size() == 0)
			$display("sample_window_validate_average_core test passed");
		else
			$display("sample_window_validate_average_core test failed");
		$finish;
	end

	initial begin : watchdog
		#1_500_000;
		$display("sample_window_validate_average_core test failed");
		$finish;
	end

endmodule
